### src/lru_key_value_cache_defines.svh
// Assertion macros for the key/value cache.
// Both sample on clk and are disabled while rst is high.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// same-cycle implication
`define LKV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic signed [31:0] MISS_VALUE = -32'sd1;
  localparam logic [4:0]         CAP_RESET  = 5'd16;

  typedef struct packed {
    logic               op;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] value_res;
  } rsp_t;

endpackage

`default_nettype wire

### src/lkv_if.sv
`default_nettype none

// request channel
interface lkv_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

// response channel
interface lkv_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] value_res;

  modport source (output valid, output hit, output value_res, input ready);
  modport sink   (input valid, input hit, input value_res, output ready);
endinterface

`default_nettype wire

### src/lkv_store.sv
`default_nettype none

module lkv_store #(
  parameter int  MAX_ENTRIES = 16,
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire lkv_pkg::req_t    req,
  input  wire logic [4:0]       capacity,
  output lkv_pkg::rsp_t         rsp,
  output logic [CNT_W-1:0]      count
);

  localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

  logic signed [31:0] keys   [MAX_ENTRIES];
  logic signed [31:0] values [MAX_ENTRIES];
  logic [RANK_W-1:0]  rank      [MAX_ENTRIES];
  logic [RANK_W-1:0]  rank_next [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] valid, match, victim, target, bump;
  logic [CNT_W-1:0]       count_next, count_m1;
  logic [CMP_W-1:0]       cap_eff;
  logic                   is_put, hit, full, insert_free, update;
  logic [RANK_W-1:0]      hit_rank;
  logic signed [31:0]     hit_value;

  always_comb begin
    is_put   = (req.op == lkv_pkg::OP_PUT);
    count_m1 = count - CNT_W'(1);

    if (capacity == 5'd0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
    full = (CMP_W'(count) >= cap_eff);

    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      // slots fill in order and never empty, so valid is index below count
      valid[i]  = (CNT_W'(i) < count);
      match[i]  = valid[i] && (keys[i] == req.key);
      // ranks of valid slots are a permutation, the oldest holds count-1
      victim[i] = valid[i] && (CNT_W'(rank[i]) == count_m1);
      hit_rank  = hit_rank  | (match[i] ? rank[i]   : '0);
      hit_value = hit_value | (match[i] ? values[i] : '0);
    end
    hit = |match;

    insert_free = is_put && !hit && !full;
    update      = hit || is_put;

    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit) begin
        target[i] = match[i];
      end else if (full) begin
        target[i] = victim[i];
      end else begin
        target[i] = (CNT_W'(i) == count);
      end
      // on a miss every other valid slot ages; on a hit only the younger ones
      bump[i] = valid[i] && !target[i] && (!hit || (rank[i] < hit_rank));
      if (target[i]) begin
        rank_next[i] = '0;
      end else if (bump[i]) begin
        rank_next[i] = rank[i] + RANK_W'(1);
      end else begin
        rank_next[i] = rank[i];
      end
    end

    count_next = count + CNT_W'(insert_free);

    rsp.hit       = hit;
    rsp.value_res = hit ? hit_value : lkv_pkg::MISS_VALUE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (fire && update) begin
      count <= count_next;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_put) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (target[i]) begin
          keys[i]   <= req.key;
          values[i] <= req.value;
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/lkv_out_reg.sv
`default_nettype none

module lkv_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire lkv_pkg::rsp_t data,
  output logic               space,
  lkv_rsp_if.source          rsp
);

  logic          valid;
  lkv_pkg::rsp_t data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= data;
    end
  end

  assign space         = !valid || rsp.ready;
  assign rsp.valid     = valid;
  assign rsp.hit       = data_q.hit;
  assign rsp.value_res = data_q.value_res;

endmodule

`default_nettype wire

### src/lru_key_value_cache.sv
// A get passes from the request register into the result register when the
//   result register has room; until then it holds the request register.
// Throughput: one request per cycle while no get waits for that room, set by
//   the combinational key compare and rank update feeding the state registers.
// Reset (synchronous, active high): empties the cache, zeroes the ranks,
//   sets capacity to 16 and drops any request or result in flight.
`default_nettype none

`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  lkv_req_if.sink         req,
  lkv_rsp_if.source       rsp,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // capacity register; the user must write it only while idle, unchecked by the block
  logic [4:0] capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Request register. The held request is resolved against the store in the
  // cycle it sits here; it leaves when its state update can be committed,
  // i.e. always for a put, and for a get once the result register has room.
  logic            s1_valid;
  lkv_pkg::req_t   s1_req;
  logic            s1_adv;
  logic            res_load;
  logic            res_space;
  lkv_pkg::rsp_t   lookup;
  logic [CNT_W-1:0] count;
  logic            get_blocked;

  assign s1_adv    = s1_valid && ((s1_req.op == lkv_pkg::OP_PUT) || res_space);
  assign res_load  = s1_adv && (s1_req.op == lkv_pkg::OP_GET);
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req.op    <= req.op;
      s1_req.key   <= req.key;
      s1_req.value <= req.value;
    end
  end

  // Key/value state: parallel compare, recency ranks, occupancy.
  // State commits on the same edge the next request is captured, so a
  // following request always sees the updated contents.
  lkv_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .fire     (s1_adv),
    .req      (s1_req),
    .capacity (capacity),
    .rsp      (lookup),
    .count    (count)
  );

  // Result register: parts the response side from the request side, so a
  // new request is taken while a result waits for its transfer.
  lkv_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res_load),
    .data  (lookup),
    .space (res_space),
    .rsp   (rsp)
  );

  // held get whose result register is full and not draining
  assign get_blocked = s1_valid && (s1_req.op == lkv_pkg::OP_GET) && rsp.valid && !rsp.ready;

  // a get that leaves the request register shows up on the response side
  `LKV_ASSERT_NEXT(a_get_to_rsp, res_load, rsp.valid, "get result lost")
  // a get blocked by a stalled result must stall the request side
  `LKV_ASSERT_NOW(a_get_stall, get_blocked, !req.ready, "request taken over blocked get")
  // occupancy never passes the slot count
  `LKV_ASSERT_NOW(a_count_max, 1'b1, count <= CNT_W'(MAX_ENTRIES), "occupancy overflow")

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

// Testbench for the LRU key/value cache.
// Requests are driven on the falling edge and handshakes are sampled on the
// rising edge. A shadow of the cache (slots, ranks, fill count, capacity)
// predicts every lookup result. Results are checked in order, field by field.
module tb;

  localparam int SLOTS = 16;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  lkv_req_if req ();
  lkv_rsp_if rsp ();

  lru_key_value_cache #(
    .MAX_ENTRIES(SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the cache contents and recency. A get pushes its predicted
  // result; a put only moves the shadow state on.
  class lru_tracker;
    logic signed [31:0] slot_key [SLOTS];
    logic signed [31:0] slot_val [SLOTS];
    bit                 slot_live[SLOTS];
    int unsigned        slot_age [SLOTS];   // 0 = most recent
    int unsigned        filled;
    logic [4:0]         capacity;
    lkv_pkg::rsp_t      lookup_q[$];
    int                 mismatches, requests, lookups, hits, evictions;

    function new();
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot_age[i]  = 0;
      end
      filled   = 0;
      capacity = lkv_pkg::CAP_RESET;
    endfunction

    // zero acts as one, anything above the slot count as the slot count
    function int unsigned eff_capacity();
      if (capacity == 0) return 1;
      if (capacity > SLOTS) return SLOTS;
      return capacity;
    endfunction

    // live slots more recent than s age by one, s becomes most recent
    function void make_recent(int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < SLOTS; i++)
        if (i != s && slot_live[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    function void take_request(lkv_pkg::req_t q);
      int            s, spare, oldest;
      int unsigned   oldest_age;
      bit            seen;
      lkv_pkg::rsp_t want;
      s      = -1;
      spare  = -1;
      requests++;
      for (int i = 0; i < SLOTS; i++) begin
        if (s < 0 && slot_live[i] && slot_key[i] == q.key) s = i;
        if (spare < 0 && !slot_live[i]) spare = i;
      end
      if (q.op == lkv_pkg::OP_GET) begin
        lookups++;
        if (s >= 0) begin
          make_recent(s);
          want.hit       = 1'b1;
          want.value_res = slot_val[s];
          hits++;
        end else begin
          want.hit       = 1'b0;
          want.value_res = lkv_pkg::MISS_VALUE;
        end
        lookup_q.push_back(want);
        return;
      end
      // put of a present key: update in place, no eviction
      if (s >= 0) begin
        slot_val[s] = q.value;
        make_recent(s);
        return;
      end
      if (filled >= eff_capacity() || spare < 0) begin
        // full, or capacity lowered under the fill count: replace the oldest,
        // lowest index on a tie
        oldest     = 0;
        oldest_age = 0;
        seen       = 1'b0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_live[i] && (!seen || slot_age[i] > oldest_age)) begin
            oldest     = i;
            oldest_age = slot_age[i];
            seen       = 1'b1;
          end
        slot_key[oldest] = q.key;
        slot_val[oldest] = q.value;
        make_recent(oldest);
        evictions++;
        return;
      end
      for (int i = 0; i < SLOTS; i++)
        if (slot_live[i]) slot_age[i]++;
      slot_key[spare]  = q.key;
      slot_val[spare]  = q.value;
      slot_live[spare] = 1'b1;
      slot_age[spare]  = 0;
      filled++;
    endfunction

    task check_lookup(lkv_pkg::rsp_t got);
      lkv_pkg::rsp_t want;
      if (lookup_q.size() == 0) begin
        report($sformatf("result hit=%0b value=%0d with no lookup outstanding",
                         got.hit, got.value_res));
        return;
      end
      want = lookup_q.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit %0b, want %0b", got.hit, want.hit));
      if (got.value_res !== want.value_res)
        report($sformatf("value_res %0d, want %0d", got.value_res, want.value_res));
    endtask

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function int outstanding();
      return lookup_q.size();
    endfunction
  endclass

  lru_tracker tracker = new();

  bit quiet;        // no idling on either side while set
  bit hold_rsp;     // asks the receiver for one long hold-off
  int settings;     // capacity writes issued

  // fixed capacity sweep: extremes, zero, over-range, and a drop from 16 to 3
  // taken while the cache is well filled
  int phase_cap[12] = '{1, 2, 5, 0, 16, 3, 31, 17, 8, 4, 12, 16};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // One request transfer. Valid stays high straight into the next request
  // when there is no gap, so it is never dropped and raised in one step.
  task automatic send_item(logic op, logic signed [31:0] key, logic signed [31:0] value);
    int            gap;
    lkv_pkg::req_t q;
    gap = quiet ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.key   <= key;
    req.value <= value;
    do @(posedge clk); while (!req.ready);
    q.op    = op;
    q.key   = key;
    q.value = value;
    tracker.take_request(q);
  endtask

  // Capacity is only changed with the cache idle: every lookup answered and a
  // wait so that a trailing put has left the pipeline.
  task automatic write_capacity(logic [4:0] cap);
    @(negedge clk);
    req.valid <= 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.capacity = cap;
    settings++;
  endtask

  // Random traffic over a key set a little larger than the capacity, so both
  // hits and evictions are common. Extreme keys creep into the set.
  task automatic run_phase(int n, bit lookup_heavy);
    logic signed [31:0] pool[$];
    logic signed [31:0] k;
    int                 span, r;
    span = tracker.eff_capacity() + $urandom_range(1, 6);
    repeat (span) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: pool.push_back(32'sh8000_0000);
          1: pool.push_back(32'sh7fff_ffff);
          2: pool.push_back(32'sh0);
          default: pool.push_back(-32'sd1);
        endcase
      end else begin
        pool.push_back($urandom);
      end
    end
    repeat (n) begin
      k = pool[$urandom_range(0, pool.size() - 1)];
      r = $urandom_range(0, 99);
      if (r < (lookup_heavy ? 75 : 40))
        send_item(lkv_pkg::OP_GET, k, $urandom);
      else if (r < (lookup_heavy ? 82 : 48))
        send_item(lkv_pkg::OP_GET, $urandom, $urandom);   // almost surely a miss
      else
        send_item(lkv_pkg::OP_PUT, k, $urandom);
    end
  endtask

  // Receiver: runs of ready, gaps of random length, and one long hold-off on
  // request, counted here so the sender keeps offering meanwhile.
  initial begin
    int left;
    bit level;
    rsp.ready = 1'b0;
    left      = 0;
    level     = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (149) @(negedge clk);
        hold_rsp = 1'b0;
        left     = 0;
      end else begin
        if (left == 0) begin
          if (level && !quiet) begin
            level = 1'b0;
            left  = idle_len();
          end
          if (left == 0) begin
            level = 1'b1;
            left  = $urandom_range(1, 24);
          end
        end
        rsp.ready <= level;
        left--;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    lkv_pkg::rsp_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.hit       = rsp.hit;
      got.value_res = rsp.value_res;
      tracker.check_lookup(got);
    end
  end

  initial begin
    int guard;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.op    = lkv_pkg::OP_GET;
    req.key   = '0;
    req.value = '0;
    quiet     = 1'b0;
    hold_rsp  = 1'b0;
    settings  = 0;
    guard     = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset capacity, lookup on an empty cache, extreme keys and
    // values, a stored -1, update of a present key
    send_item(lkv_pkg::OP_GET, 32'sh0, 32'sh7fff_ffff);
    send_item(lkv_pkg::OP_PUT, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(lkv_pkg::OP_PUT, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(lkv_pkg::OP_PUT, 32'sh0, 32'sh0);
    send_item(lkv_pkg::OP_PUT, -32'sd1, -32'sd1);
    send_item(lkv_pkg::OP_GET, 32'sh8000_0000, $urandom);
    send_item(lkv_pkg::OP_GET, 32'sh7fff_ffff, $urandom);
    send_item(lkv_pkg::OP_GET, -32'sd1, $urandom);
    send_item(lkv_pkg::OP_PUT, 32'sh0, 32'sh1234_5678);
    send_item(lkv_pkg::OP_GET, 32'sh0, $urandom);
    send_item(lkv_pkg::OP_GET, 32'sd5, $urandom);
    // capacity dropped under the fill count: nothing flushed, new keys replace
    write_capacity(5'd2);
    send_item(lkv_pkg::OP_PUT, 32'sd100, 32'sha5a5_a5a5);
    send_item(lkv_pkg::OP_GET, 32'sh8000_0000, $urandom);
    send_item(lkv_pkg::OP_GET, 32'sd100, $urandom);
    send_item(lkv_pkg::OP_PUT, 32'sh7fff_ffff, 32'sd1);
    // zero capacity behaves as one
    write_capacity(5'd0);
    send_item(lkv_pkg::OP_PUT, 32'sd200, 32'sd2);
    send_item(lkv_pkg::OP_PUT, 32'sd201, 32'sd3);
    send_item(lkv_pkg::OP_GET, 32'sd200, $urandom);
    send_item(lkv_pkg::OP_GET, 32'sd201, $urandom);
    // over-range capacity behaves as the slot count
    write_capacity(5'd31);
    send_item(lkv_pkg::OP_PUT, 32'sd300, -32'sd300);
    send_item(lkv_pkg::OP_PUT, 32'sd301, 32'sd301);
    send_item(lkv_pkg::OP_GET, 32'sd300, $urandom);
    send_item(lkv_pkg::OP_GET, -32'sd1, $urandom);

    // Random part, one phase per capacity setting; every fourth phase runs
    // without idling, one lookup-heavy phase meets the long receiver hold-off
    for (int p = 0; p < 12; p++) begin
      write_capacity(5'(phase_cap[p]));
      quiet = (p % 4 == 3);
      if (p == 6) hold_rsp = 1'b1;
      run_phase(36, p == 6 || p == 9);
    end
    quiet = 1'b0;

    @(negedge clk);
    req.valid <= 1'b0;
    while (tracker.outstanding() > 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (tracker.outstanding() > 0)
      tracker.report($sformatf("%0d lookups never answered", tracker.outstanding()));

    $display("tb: %0d request transfers, %0d lookups (%0d hits), %0d evictions",
             tracker.requests, tracker.lookups, tracker.hits, tracker.evictions);
    $display("tb: %0d capacity settings incl. 0, 1, 16, 31; %0d mismatches",
             settings, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_200_000;
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
